### rtl/scd_pkg.sv
`default_nettype none

package scd_pkg;

    // One scanned byte and its position in the switch chain.
    typedef struct packed {
        logic [2:0] byte_index;
        logic [7:0] raw_byte;
    } scan_t;

    // One change event.
    typedef struct packed {
        logic [5:0] switch_number;
        logic       switch_state;
        logic       last_event;
    } change_t;

    // A scanned byte that differs from its stored copy, waiting to be unpacked into events.
    typedef struct packed {
        logic [2:0] pos;
        logic [7:0] now;
        logic [7:0] diff;
    } job_t;

endpackage

`default_nettype wire

### rtl/scd_front.sv
`default_nettype none

module scd_front #(
    parameter int SWITCH_BYTES = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          scan_valid,
    output logic               scan_stall,
    input  wire scd_pkg::scan_t scan,
    output logic               job_valid,
    output scd_pkg::job_t      job,
    input  wire logic          job_load
);

    localparam int IDX_W = (SWITCH_BYTES > 1) ? $clog2(SWITCH_BYTES) : 1;

    logic [7:0]     store_reg [SWITCH_BYTES];
    logic           job_valid_reg;
    logic           job_valid_next;
    scd_pkg::job_t  job_reg;
    logic           accept;
    logic           in_range;
    logic [IDX_W-1:0] addr;
    logic [7:0]     diff;
    logic           hit;

    assign addr     = IDX_W'(scan.byte_index);
    assign in_range = 32'(scan.byte_index) < SWITCH_BYTES;
    assign diff     = scan.raw_byte ^ store_reg[addr];
    assign hit      = in_range && (diff != 8'd0);

    // The job register frees up in the same cycle the emitter takes its contents.
    assign scan_stall = job_valid_reg && !job_load;
    assign accept     = scan_valid && !scan_stall;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (!job_valid_reg || job_load)
        begin
            job_valid_next = accept && hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            for (int i = 0; i < SWITCH_BYTES; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            if (accept && in_range)
            begin
                store_reg[addr] <= scan.raw_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.pos  <= scan.byte_index;
            job_reg.now  <= scan.raw_byte;
            job_reg.diff <= diff;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

### rtl/scd_emit.sv
`default_nettype none

module scd_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    input  wire scd_pkg::job_t  job,
    output logic                job_load,
    output logic                chg_valid,
    input  wire logic           chg_stall,
    output scd_pkg::change_t    chg
);

    logic [7:0]        mask_reg;
    logic [7:0]        mask_next;
    logic [2:0]        pos_reg;
    logic [7:0]        now_reg;
    logic              out_valid_reg;
    scd_pkg::change_t  out_reg;
    logic              pend;
    logic              out_free;
    logic              fire;
    logic [2:0]        sel_j;
    logic [2:0]        sel_bit;
    logic [7:0]        rest;

    // Pick the lowest j whose raw bit 7-j is still pending: the first bit shifted in goes first.
    always_comb
    begin
        sel_j = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            if (mask_reg[7 - j])
            begin
                sel_j = 3'(j);
            end
        end
    end

    assign sel_bit  = 3'd7 - sel_j;
    assign rest     = mask_reg & ~(8'd1 << sel_bit);
    assign pend     = mask_reg != 8'd0;
    assign out_free = !out_valid_reg || !chg_stall;
    assign fire     = pend && out_free;
    assign job_load = job_valid && (!pend || (fire && (rest == 8'd0)));

    always_comb
    begin
        mask_next = mask_reg;
        if (job_load)
        begin
            mask_next = job.diff;
        end
        else if (fire)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!chg_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            pos_reg <= job.pos;
            now_reg <= job.now;
        end
        if (fire)
        begin
            out_reg.switch_number <= {pos_reg, sel_j};
            out_reg.switch_state  <= now_reg[sel_bit];
            out_reg.last_event    <= rest == 8'd0;
        end
    end

    assign chg_valid = out_valid_reg;
    assign chg       = out_reg;

endmodule

`default_nettype wire

### rtl/switch_scan_change_detector_core.sv
`default_nettype none

// Switch scan change detector. Each scan beat carries one byte of a switch bank and its
// position; the byte is compared with the copy kept for that position (all zeros after
// reset), and one change beat comes out per changed bit, in ascending switch number
// (position * 8 + j, where j selects raw bit 7-j), with last_event set on the final one.
// Positions at or beyond SWITCH_BYTES are dropped without effect. A byte with k changed
// bits yields k events, up to eight, and the event emitter, which hands out one event per
// cycle while the consumer does not stall, sets the sustained rate. A byte with no change
// never reaches the emitter. A scan beat passes the job register, the emitter's mask
// register and then the output register before its first event appears. While a byte
// waits in the job register, the scan input stalls until the emitter takes it, and the
// output register holds one beat for a stalled consumer.
module switch_scan_change_detector_core #(
    parameter int SWITCH_BYTES = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            scan_valid,
    output logic                 scan_stall,
    input  wire scd_pkg::scan_t  scan,
    output logic                 chg_valid,
    input  wire logic            chg_stall,
    output scd_pkg::change_t     chg
);

    logic           job_valid;
    scd_pkg::job_t  job;
    logic           job_load;

    scd_front #(
        .SWITCH_BYTES (SWITCH_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan       (scan),
        .job_valid  (job_valid),
        .job        (job),
        .job_load   (job_load)
    );

    scd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_load  (job_load),
        .chg_valid (chg_valid),
        .chg_stall (chg_stall),
        .chg       (chg)
    );

endmodule

`default_nettype wire

### verif/change_event_checker.sv
module change_event_checker #(
    parameter int SWITCH_BYTES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             scan_valid,
    input  logic             scan_stall,
    input  scd_pkg::scan_t   scan,
    input  logic             chg_valid,
    input  logic             chg_stall,
    input  scd_pkg::change_t chg,
    output int               failures,
    output int               pending
);

    logic [7:0]       last_seen [SWITCH_BYTES];
    scd_pkg::change_t expected_changes [$];

    // Queues one event per changed bit, with the most significant bit first.
    function automatic void predict_changes(input scd_pkg::scan_t beat);
        logic [7:0]       flipped;
        scd_pkg::change_t ev;
        if (beat.byte_index >= SWITCH_BYTES)
            return;
        flipped = beat.raw_byte ^ last_seen[beat.byte_index];
        for (int j = 0; j < 8; j++)
        begin
            if (flipped[7 - j])
            begin
                ev.switch_number = {beat.byte_index, 3'(j)};
                ev.switch_state  = beat.raw_byte[7 - j];
                // The final event is the one with no changed bit below it.
                ev.last_event    = ((flipped & ((8'd1 << (7 - j)) - 8'd1)) == 8'd0);
                expected_changes.push_back(ev);
            end
        end
        last_seen[beat.byte_index] = beat.raw_byte;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scd_pkg::change_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SWITCH_BYTES; i++)
                last_seen[i] = 8'd0;
            expected_changes.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            // Results are checked before the scan of the same edge is predicted.
            if (chg_valid && !chg_stall)
            begin
                if (expected_changes.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected change beat: expected none, %s %0d %0d %0d",
                             $time, "actual switch/state/last",
                             chg.switch_number, chg.switch_state, chg.last_event);
                end
                else
                begin
                    want = expected_changes.pop_front();
                    if (chg !== want)
                    begin
                        failures++;
                        $display("%0t: change beat mismatch: expected switch %0d state %0d last %0d",
                                 $time, want.switch_number, want.switch_state,
                                 want.last_event);
                        $display("%0t:   actual switch %0d state %0d last %0d",
                                 $time, chg.switch_number, chg.switch_state,
                                 chg.last_event);
                    end
                end
            end
            if (scan_valid && !scan_stall)
                predict_changes(scan);
            pending <= expected_changes.size();
        end
    end

endmodule

### verif/testbench.sv
module testbench;

    localparam int SWITCH_BYTES = 8;
    localparam int HOLD_CYCLES  = 100;
    localparam int QUIET_LIMIT  = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             scan_valid = 1'b0;
    logic             scan_stall;
    scd_pkg::scan_t   scan = '0;
    logic             chg_valid;
    logic             chg_stall = 1'b0;
    scd_pkg::change_t chg;

    int failures;
    int pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Bytes last offered at each position, used to shape the random scans.
    logic [7:0] sent_bytes [SWITCH_BYTES];

    switch_scan_change_detector_core #(
        .SWITCH_BYTES(SWITCH_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .scan_valid(scan_valid),
        .scan_stall(scan_stall),
        .scan(scan),
        .chg_valid(chg_valid),
        .chg_stall(chg_stall),
        .chg(chg)
    );

    change_event_checker #(
        .SWITCH_BYTES(SWITCH_BYTES)
    ) event_check (
        .clk(clk),
        .rst_n(rst_n),
        .scan_valid(scan_valid),
        .scan_stall(scan_stall),
        .scan(scan),
        .chg_valid(chg_valid),
        .chg_stall(chg_stall),
        .chg(chg),
        .failures(failures),
        .pending(pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Change receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            chg_stall <= 1'b1;
            hold_left--;
        end
        else
            chg_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (scan_valid && !scan_stall) || (chg_valid && !chg_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_scan(input logic [2:0] idx, input logic [7:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            scan_valid <= 1'b0;
            @(posedge clk);
        end
        scan_valid <= 1'b1;
        scan <= '{byte_index: idx, raw_byte: value};
        @(posedge clk);
        while (scan_stall)
            @(posedge clk);
        sent_bytes[idx] = value;
    endtask

    // Half repeats and single-bit flips of the last byte, the other half fully random.
    task automatic send_random_scans(input int count);
        logic [2:0] idx;
        logic [7:0] value;
        int         pick;
        for (int n = 0; n < count; n++)
        begin
            idx = 3'($urandom_range(SWITCH_BYTES - 1));
            pick = $urandom_range(99);
            if (pick < 20)
                value = sent_bytes[idx];
            else if (pick < 50)
                value = sent_bytes[idx] ^ (8'd1 << $urandom_range(7));
            else
                value = 8'($urandom_range(255));
            send_scan(idx, value);
        end
    endtask

    task automatic drain_changes();
        scan_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    initial
    begin
        for (int i = 0; i < SWITCH_BYTES; i++)
            sent_bytes[i] = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans. A byte equal to the stored one must produce no event;
        // the first of these hits the cleared store.
        send_scan(3'd0, 8'h00);
        send_scan(3'd0, 8'hFF);
        send_scan(3'd0, 8'hFF);
        send_scan(3'd0, 8'h00);
        send_scan(3'd7, 8'hFF);
        send_scan(3'd7, 8'h80);
        send_scan(3'd7, 8'h01);
        send_scan(3'd3, 8'h01);
        send_scan(3'd3, 8'h80);
        send_scan(3'd5, 8'hAA);
        send_scan(3'd5, 8'h55);
        send_scan(3'd1, 8'h01);
        send_scan(3'd2, 8'h10);
        send_scan(3'd4, 8'hF0);
        send_scan(3'd6, 8'h0F);
        send_scan(3'd6, 8'h0F);

        idle_pct = 29;
        stall_pct = 69;
        send_random_scans(25);
        idle_pct = 69;
        stall_pct = 29;
        send_random_scans(25);
        idle_pct = 0;
        stall_pct = 0;
        send_random_scans(25);

        // Hold the receiver off while full-byte changes keep arriving, so the
        // block backs up and stalls its scan input, then let everything drain.
        hold_requests++;
        for (int n = 0; n < 12; n++)
        begin
            send_scan(3'(n % SWITCH_BYTES), sent_bytes[n % SWITCH_BYTES] ^ 8'hFF);
        end
        drain_changes();
        send_random_scans(10);

        drain_changes();
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
